/* rtl/usp_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 space stripper package
// Shared types and constants for the space stripper: the prefix hold state,
// one result entry and the group of results that one input byte causes.
// ----------------------------------------------------------------------------
package usp_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned GroupSize  = 3;

  localparam logic [7:0] ByteSpace = 8'h20;
  localparam logic [7:0] ByteC2    = 8'hC2;
  localparam logic [7:0] ByteA0    = 8'hA0;
  localparam logic [7:0] ByteE2    = 8'hE2;
  localparam logic [7:0] Byte80    = 8'h80;
  localparam logic [7:0] Byte82    = 8'h82;
  localparam logic [7:0] Byte83    = 8'h83;
  localparam logic [7:0] Byte89    = 8'h89;
  localparam logic [7:0] ByteAF    = 8'hAF;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_C2   = 2'd1,
    HOLD_E2   = 2'd2,
    HOLD_E280 = 2'd3
  } hold_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]                  cnt;
    result_t [GroupSize-1:0]     item;
  } group_t;

endpackage

/* rtl/usp_decode.sv */
// ----------------------------------------------------------------------------
// UTF-8 space stripper decoder
// Classifies one input byte against the held prefix and forms the group of
// up to three results together with the next hold state.
// ----------------------------------------------------------------------------
module usp_decode
  import usp_pkg::*;
(
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  hold_e      hold_i,
  output group_t     group_o,
  output hold_e      hold_o
);

  function automatic group_t push_byte(group_t g, logic [7:0] b);
    if (g.cnt != 2'd3) begin
      g.item[g.cnt].data     = b;
      g.item[g.cnt].has_byte = 1'b1;
      g.item[g.cnt].last     = 1'b0;
      g.cnt                  = g.cnt + 2'd1;
    end
    return g;
  endfunction

  function automatic group_t push_held(group_t g, hold_e h);
    group_t r;
    r = g;
    case (h)
      HOLD_C2:   r = push_byte(r, ByteC2);
      HOLD_E2:   r = push_byte(r, ByteE2);
      HOLD_E280: begin
        r = push_byte(r, ByteE2);
        r = push_byte(r, Byte80);
      end
      default:   r = g;
    endcase
    return r;
  endfunction

  group_t grp;
  hold_e  hold_mid;
  hold_e  hold_d;
  logic   hit;

  always_comb begin
    case (hold_i)
      HOLD_C2:   hit = (byte_i == ByteA0);
      HOLD_E2:   hit = (byte_i == Byte80);
      HOLD_E280: hit = (byte_i inside {Byte82, Byte83, Byte89, ByteAF});
      default:   hit = 1'b0;
    endcase

    if (hit) begin
      hold_mid = (hold_i == HOLD_E2) ? HOLD_E280 : HOLD_NONE;
    end else if (byte_i == ByteC2) begin
      hold_mid = HOLD_C2;
    end else if (byte_i == ByteE2) begin
      hold_mid = HOLD_E2;
    end else begin
      hold_mid = HOLD_NONE;
    end

    hold_d = last_i ? HOLD_NONE : hold_mid;
  end

  always_comb begin
    grp = '0;
    if (!hit) begin
      grp = push_held(grp, hold_i);
      if (!(byte_i inside {ByteSpace, ByteC2, ByteE2})) begin
        grp = push_byte(grp, byte_i);
      end
    end

    if (last_i) begin
      grp = push_held(grp, hold_mid);
      if (grp.cnt == 2'd0) begin
        grp.cnt              = 2'd1;
        grp.item[0].data     = 8'h00;
        grp.item[0].has_byte = 1'b0;
        grp.item[0].last     = 1'b1;
      end else begin
        grp.item[grp.cnt - 2'd1].last = 1'b1;
      end
    end
  end

  assign group_o = grp;
  assign hold_o  = hold_d;

endmodule

/* rtl/usp_queue.sv */
// ----------------------------------------------------------------------------
// UTF-8 space stripper result queue
// Takes a group of up to three results in one cycle and hands them out one
// per transaction in order.
// ----------------------------------------------------------------------------
module usp_queue
  import usp_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_en_i,
  input  group_t  group_i,
  output logic    room_o,
  output logic    valid_o,
  output result_t head_o,
  input  logic    rd_en_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] RoomMax = CW'(DEPTH - GroupSize);
  localparam logic [AW+1:0] DepthW  = (AW + 2)'(DEPTH);

  result_t        mem_q [DEPTH];
  logic [AW-1:0]  wptr_q, wptr_d;
  logic [AW-1:0]  rptr_q, rptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  widx [GroupSize];
  logic [AW+1:0]  sum  [GroupSize+1];
  logic [CW-1:0]  wr_cnt;

  always_comb begin
    for (int i = 0; i <= GroupSize; i++) begin
      sum[i] = {2'b00, wptr_q} + (AW + 2)'(i);
      if (sum[i] >= DepthW) begin
        sum[i] = sum[i] - DepthW;
      end
    end
    for (int i = 0; i < GroupSize; i++) begin
      widx[i] = sum[i][AW-1:0];
    end
  end

  assign wr_cnt = wr_en_i ? CW'(group_i.cnt) : '0;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    case (group_i.cnt)
      2'd1:    wptr_d = sum[1][AW-1:0];
      2'd2:    wptr_d = sum[2][AW-1:0];
      2'd3:    wptr_d = sum[3][AW-1:0];
      default: wptr_d = wptr_q;
    endcase
    if (!wr_en_i) begin
      wptr_d = wptr_q;
    end
    if (rd_en_i) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    count_d = count_q + wr_cnt - (rd_en_i ? CW'(1) : CW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < GroupSize; i++) begin
      if (wr_en_i && (2'(i) < group_i.cnt)) begin
        mem_q[widx[i]] <= group_i.item[i];
      end
    end
  end

  assign room_o  = (count_q <= RoomMax);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("Queue count exceeds its depth.");

  a_write_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> room_o)
    else $error("Group written without room for it.");

  a_read_only_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && !wr_en_i) |=> count_q == $past(count_q) - CW'(1))
    else $error("Read transaction did not drain one entry.");

  a_write_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && !rd_en_i) |=> count_q == $past(count_q) + CW'($past(group_i.cnt)))
    else $error("Group write did not add its results.");

endmodule

/* rtl/utf8_space_stripper_top.sv */
// ----------------------------------------------------------------------------
// UTF-8 space stripper
// Removes ASCII, no-break and selected Unicode spaces from a byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the queue has room and writes
// the up to three results that the byte causes into a small result queue
// in the same cycle; the queue hands out one result per transaction, so a
// result leaves at the earliest in the cycle after its byte. Input is
// stalled only while the queue has fewer than three free entries, which at
// the default depth of eight happens only when the output side stalls.
module utf8_space_stripper_top
  import usp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_has_byte_o,
  output logic       out_end_o
);

  hold_e   hold_q, hold_d;
  group_t  grp;
  logic    room;
  logic    in_fire;
  logic    out_fire;
  result_t head;

  usp_decode u_decode (
    .byte_i  (in_byte_i),
    .last_i  (in_last_i),
    .hold_i  (hold_q),
    .group_o (grp),
    .hold_o  (hold_d)
  );

  assign in_stall_o = !room;
  assign in_fire    = in_valid_i && room;
  assign out_fire   = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_NONE;
    end else if (in_fire) begin
      hold_q <= hold_d;
    end
  end

  usp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (in_fire),
    .group_i (grp),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head),
    .rd_en_i (out_fire)
  );

  assign out_byte_o     = head.data;
  assign out_has_byte_o = head.has_byte;
  assign out_end_o      = head.last;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 space stripper testbench
// Feeds strings of UTF-8 bytes, directed first and then random, through the
// stripper and checks every kept byte and end mark against a built-in model
// of the prefix hold logic, under random sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
  import usp_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  localparam logic [7:0] ThirdBytes [4] = '{Byte82, Byte83, Byte89, ByteAF};

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [7:0] in_byte_i      = 8'h00;
  logic       in_last_i      = 1'b0;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       out_has_byte_o;
  logic       out_end_o;

  text_item_t pending_q [$];
  result_t    kept_q [$];
  hold_e      held = HOLD_NONE;
  text_item_t cur;
  result_t    want;
  logic       in_taken = 1'b0;
  logic       hold_req = 1'b0;
  int         hold_left = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         errors = 0;

  utf8_space_stripper_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .out_has_byte_o(out_has_byte_o),
    .out_end_o     (out_end_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (errors < 50) $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic int release_held();
    int n;
    n = 0;
    case (held)
      HOLD_C2: begin
        kept_q.push_back('{data: ByteC2, has_byte: 1'b1, last: 1'b0});
        n = 1;
      end
      HOLD_E2: begin
        kept_q.push_back('{data: ByteE2, has_byte: 1'b1, last: 1'b0});
        n = 1;
      end
      HOLD_E280: begin
        kept_q.push_back('{data: ByteE2, has_byte: 1'b1, last: 1'b0});
        kept_q.push_back('{data: Byte80, has_byte: 1'b1, last: 1'b0});
        n = 2;
      end
      default: n = 0;
    endcase
    held = HOLD_NONE;
    return n;
  endfunction

  task automatic strip_byte(input logic [7:0] ch, input logic last);
    int   n;
    logic done;
    n = 0;
    done = (held == HOLD_C2 && ch == ByteA0) || (held == HOLD_E2 && ch == Byte80) ||
           (held == HOLD_E280 && (ch == Byte82 || ch == Byte83 || ch == Byte89 ||
                                  ch == ByteAF));
    if (done) begin
      held = (held == HOLD_E2) ? HOLD_E280 : HOLD_NONE;
    end else begin
      n = release_held();
      if (ch == ByteC2) begin
        held = HOLD_C2;
      end else if (ch == ByteE2) begin
        held = HOLD_E2;
      end else if (ch != ByteSpace) begin
        kept_q.push_back('{data: ch, has_byte: 1'b1, last: 1'b0});
        n++;
      end
    end
    if (last) begin
      n += release_held();
      if (n == 0) kept_q.push_back('{data: 8'h00, has_byte: 1'b0, last: 1'b1});
      else kept_q[kept_q.size()-1].last = 1'b1;
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        cur = pending_q.pop_front();
        in_valid_i <= 1'b1;
        in_byte_i  <= cur.ch;
        in_last_i  <= cur.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 150;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) strip_byte(in_byte_i, in_last_i);
      if (out_valid_o && !out_stall_i) begin
        if (kept_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, byte %h", out_byte_o));
        end else begin
          want = kept_q.pop_front();
          if (out_byte_o !== want.data)
            report_mismatch($sformatf("out_byte %h, expected %h", out_byte_o, want.data));
          if (out_has_byte_o !== want.has_byte)
            report_mismatch($sformatf("out_has_byte %b, expected %b", out_has_byte_o,
                                      want.has_byte));
          if (out_end_o !== want.last)
            report_mismatch($sformatf("out_end %b, expected %b", out_end_o, want.last));
        end
      end
    end
  end

  task automatic add_text(input logic [7:0] s [$]);
    foreach (s[k]) pending_q.push_back('{ch: s[k], last: (k == s.size() - 1)});
  endtask

  task automatic fill(input int count);
    logic [7:0] s [$];
    int added;
    int tokens;
    added = 0;
    while (added < count) begin
      s.delete();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          pending_q.push_back('{ch: 8'($urandom_range(255)), last: ($urandom_range(7) == 0)});
          added++;
        end
      end else begin
        tokens = $urandom_range(1, 8);
        repeat (tokens) begin
          case ($urandom_range(9))
            0: s.push_back(ByteSpace);
            1: begin
              s.push_back(ByteC2);
              s.push_back(ByteA0);
            end
            2: begin
              s.push_back(ByteE2);
              s.push_back(Byte80);
              s.push_back(ThirdBytes[$urandom_range(3)]);
            end
            3: begin
              s.push_back(ByteC2);
              s.push_back(8'($urandom_range(255)));
            end
            4: begin
              s.push_back(ByteE2);
              s.push_back(8'($urandom_range(255)));
            end
            5: begin
              s.push_back(ByteE2);
              s.push_back(Byte80);
              s.push_back(8'($urandom_range(255)));
            end
            6: begin
              s.push_back(($urandom_range(1) == 0) ? ByteC2 : ByteE2);
              if (s[s.size()-1] == ByteE2 && $urandom_range(1) == 1) s.push_back(Byte80);
            end
            default: s.push_back(8'($urandom_range(255)));
          endcase
        end
        add_text(s);
        added += s.size();
      end
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || kept_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    tx_idle_pct = 11;
    rx_idle_pct = 61;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    add_text('{8'h00, 8'hFF, ByteSpace});
    add_text('{ByteC2, ByteA0});
    add_text('{ByteE2, Byte80, Byte82, ByteE2, Byte80, Byte83, ByteE2, Byte80, Byte89,
               ByteE2, Byte80, ByteAF});
    add_text('{ByteC2, ByteE2, Byte80, ByteSpace, ByteE2, Byte80, 8'h41});
    add_text('{ByteC2});
    add_text('{ByteE2, Byte80});
    drain();

    fill(170);
    drain();

    tx_idle_pct = 61;
    rx_idle_pct = 11;
    fill(170);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(posedge clk_i);
    hold_req = 1'b1;
    fill(60);
    drain();
    fill(110);
    drain();

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
rtl/usp_pkg.sv
rtl/usp_decode.sv
rtl/usp_queue.sv
rtl/utf8_space_stripper_top.sv
bench/testbench.sv
